// ===== sv/virtq_descriptor_chain_walker_core_defines.svh =====
// Assertion macros for the descriptor chain walker.
`ifndef VIRTQ_DESCRIPTOR_CHAIN_WALKER_CORE_DEFINES_SVH
`define VIRTQ_DESCRIPTOR_CHAIN_WALKER_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define VDCW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition seen at one edge leads to another at the next edge.
`define VDCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vdcw_pkg.sv =====
// Types, codes and helpers shared by the descriptor chain walker.
package vdcw_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [31:0] SAT_MAX32 = 32'hFFFF_FFFF;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESC_TABLE_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RBUF_SIZE = 2'd2;

    localparam logic [15:0] QUEUE_SIZE_RST = 16'd256;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DESC = 2'd1;
    localparam logic [1:0] CMD_COPY = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DESC = 2'd1;
    localparam logic [1:0] PH_COPY = 2'd2;

    localparam logic [1:0] KIND_FETCH = 2'd0;
    localparam logic [1:0] KIND_COPY = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [2:0] END_CHAIN = 3'd0;
    localparam logic [2:0] END_LIMIT = 3'd1;
    localparam logic [2:0] END_BAD_INDEX = 3'd2;
    localparam logic [2:0] END_FETCH_ERR = 3'd3;
    localparam logic [2:0] END_COPY_ERR = 3'd4;
    localparam logic [2:0] END_READ_AFTER_WRITE = 3'd5;

    typedef struct packed {
        logic [15:0] queue_size;
        logic [63:0] desc_table_base;
        logic [15:0] rbuf_size;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] head_index;
        logic [63:0] desc_addr;
        logic [31:0] desc_len;
        logic        desc_write;
        logic        desc_has_next;
        logic [15:0] desc_next_index;
        logic        access_error;
    } item_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic        wr_seen;
        logic [31:0] req_total;
        logic [31:0] reply_total;
        logic        more_follow;
        logic [15:0] next_index;
        logic [15:0] walk_steps;
        logic [31:0] pending_len;
    } walk_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] fetch_addr;
        logic [63:0] copy_addr;
        logic [15:0] copy_len;
        logic [15:0] buf_offset;
        logic [31:0] req_len;
        logic [31:0] reply_len;
        logic [2:0]  end_reason;
    } result_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? SAT_MAX32 : sum[31:0];
    endfunction

endpackage

// ===== sv/vdcw_cfg_regs.sv =====
// Configuration register file of the descriptor chain walker.
module vdcw_cfg_regs
    import vdcw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_QUEUE_SIZE:      cfg_next.queue_size = cfg_data[15:0];
                REG_DESC_TABLE_BASE: cfg_next.desc_table_base = cfg_data;
                REG_RBUF_SIZE:       cfg_next.rbuf_size = cfg_data[15:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.queue_size <= QUEUE_SIZE_RST;
            cfg_reg.desc_table_base <= 64'd0;
            cfg_reg.rbuf_size <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/vdcw_step.sv =====
// Per-item decision logic: next walk state and the action to issue.
module vdcw_step
    import vdcw_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int CNT_W = $clog2(MAX_ENTRIES + 1)
)
(
    input  cfg_t             cfg,
    input  item_t            item,
    input  walk_t            cur,
    input  logic [CNT_W-1:0] entry_count,
    input  logic [CNT_W-1:0] reply_first,
    output walk_t            nxt,
    output logic [CNT_W-1:0] entry_count_next,
    output logic [CNT_W-1:0] reply_first_next,
    output logic             res_valid,
    output result_t          res,
    output logic [CNT_W-1:0] res_count,
    output logic [CNT_W-1:0] res_reply_start
);

    logic        do_sum;
    logic        do_adv;
    logic        do_fetch;
    logic [2:0]  reason;
    logic [15:0] room;

    assign room = cfg.rbuf_size - cur.req_total[15:0];

    always_comb
    begin
        nxt = cur;
        entry_count_next = entry_count;
        reply_first_next = reply_first;
        res = '0;
        res_valid = 1'b0;
        res_count = '0;
        res_reply_start = '0;
        do_sum = 1'b0;
        do_adv = 1'b0;
        do_fetch = 1'b0;
        reason = END_CHAIN;

        case (item.cmd)
            CMD_START:
            begin
                nxt.wr_seen = 1'b0;
                entry_count_next = '0;
                nxt.req_total = '0;
                nxt.reply_total = '0;
                reply_first_next = '0;
                nxt.more_follow = 1'b1;
                nxt.next_index = item.head_index;
                nxt.walk_steps = '0;
                nxt.pending_len = '0;
                do_fetch = 1'b1;
            end
            CMD_DESC:
            begin
                if (cur.phase == PH_DESC)
                begin
                    if (item.access_error)
                    begin
                        do_sum = 1'b1;
                        reason = END_FETCH_ERR;
                    end
                    else
                    begin
                        nxt.more_follow = item.desc_has_next;
                        nxt.next_index = item.desc_next_index;
                        if (!cur.wr_seen && !item.desc_write)
                        begin
                            if (cur.req_total >= {16'd0, cfg.rbuf_size})
                            begin
                                do_adv = 1'b1;
                            end
                            else
                            begin
                                nxt.pending_len = item.desc_len;
                                nxt.phase = PH_COPY;
                                res_valid = 1'b1;
                                res.kind = KIND_COPY;
                                res.copy_addr = item.desc_addr;
                                res.copy_len = (item.desc_len < {16'd0, room}) ?
                                    item.desc_len[15:0] : room;
                                res.buf_offset = cur.req_total[15:0];
                            end
                        end
                        else if (item.desc_write)
                        begin
                            nxt.wr_seen = 1'b1;
                            if (!cur.wr_seen)
                            begin
                                reply_first_next = entry_count;
                            end
                            nxt.reply_total = sat_add32(cur.reply_total, item.desc_len);
                            entry_count_next = entry_count + 1'b1;
                            do_adv = 1'b1;
                        end
                        else
                        begin
                            do_sum = 1'b1;
                            reason = END_READ_AFTER_WRITE;
                        end
                    end
                end
            end
            CMD_COPY:
            begin
                if (cur.phase == PH_COPY)
                begin
                    if (item.access_error)
                    begin
                        do_sum = 1'b1;
                        reason = END_COPY_ERR;
                    end
                    else
                    begin
                        nxt.req_total = sat_add32(cur.req_total, cur.pending_len);
                        entry_count_next = entry_count + 1'b1;
                        do_adv = 1'b1;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        if (do_adv)
        begin
            if (!nxt.more_follow)
            begin
                do_sum = 1'b1;
                reason = END_CHAIN;
            end
            else
            begin
                do_fetch = 1'b1;
            end
        end

        if (do_fetch)
        begin
            if (entry_count_next >= CNT_W'(MAX_ENTRIES))
            begin
                do_sum = 1'b1;
                reason = END_LIMIT;
            end
            else if (nxt.next_index >= cfg.queue_size)
            begin
                do_sum = 1'b1;
                reason = END_BAD_INDEX;
            end
            else if (nxt.walk_steps >= cfg.queue_size)
            begin
                do_sum = 1'b1;
                reason = END_LIMIT;
            end
            else
            begin
                nxt.walk_steps = nxt.walk_steps + 16'd1;
                nxt.phase = PH_DESC;
                res_valid = 1'b1;
                res.kind = KIND_FETCH;
                res.fetch_addr = cfg.desc_table_base + {44'd0, nxt.next_index, 4'd0};
            end
        end

        if (do_sum)
        begin
            nxt.phase = PH_IDLE;
            res_valid = 1'b1;
            res = '0;
            res.kind = KIND_SUMMARY;
            res.req_len = nxt.req_total;
            res.reply_len = nxt.reply_total;
            res.end_reason = reason;
            res_count = entry_count_next;
            res_reply_start = reply_first_next;
        end
    end

endmodule

// ===== sv/virtq_descriptor_chain_walker_core.sv =====
// Top level of the split-virtqueue descriptor chain walker.
// An accepted item reaches the input register and its action is then registered in the
// result register, which drives out_valid. Throughput: one item per cycle unless a result
// meets a full output register; the walk state updates in the same cycle as the decision.
// Reset: walk idle, counters and totals zero, queue_size 256, other configuration registers zero.
module virtq_descriptor_chain_walker_core
    import vdcw_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int CNT_W = $clog2(MAX_ENTRIES + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic [15:0]          head_index,
    input  logic [63:0]          desc_addr,
    input  logic [31:0]          desc_len,
    input  logic                 desc_write,
    input  logic                 desc_has_next,
    input  logic [15:0]          desc_next_index,
    input  logic                 access_error,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic [63:0]          fetch_addr,
    output logic [63:0]          copy_addr,
    output logic [15:0]          copy_len,
    output logic [15:0]          buf_offset,
    output logic [CNT_W-1:0]     desc_count,
    output logic [31:0]          req_len,
    output logic [CNT_W-1:0]     reply_idx,
    output logic [31:0]          reply_len,
    output logic [2:0]           end_reason
);

    `include "virtq_descriptor_chain_walker_core_defines.svh"

    cfg_t             cfg;
    logic             item_valid_reg;
    item_t            item_reg;
    walk_t            walk_reg;
    walk_t            walk_next;
    logic [CNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0] entry_count_next;
    logic [CNT_W-1:0] reply_first_reg;
    logic [CNT_W-1:0] reply_first_next;
    logic             res_valid;
    result_t          res;
    logic [CNT_W-1:0] res_count;
    logic [CNT_W-1:0] res_reply_start;
    logic             out_valid_reg;
    result_t          out_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic [CNT_W-1:0] out_reply_start_reg;
    logic             out_free;
    logic             step_go;
    logic             res_load;

    vdcw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vdcw_step #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CNT_W       (CNT_W)
    ) u_step (
        .cfg              (cfg),
        .item             (item_reg),
        .cur              (walk_reg),
        .entry_count      (entry_count_reg),
        .reply_first      (reply_first_reg),
        .nxt              (walk_next),
        .entry_count_next (entry_count_next),
        .reply_first_next (reply_first_next),
        .res_valid        (res_valid),
        .res              (res),
        .res_count        (res_count),
        .res_reply_start  (res_reply_start)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign step_go = item_valid_reg && (out_free || !res_valid);
    assign res_load = step_go && res_valid;
    assign in_ready = !item_valid_reg || step_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.cmd <= cmd;
            item_reg.head_index <= head_index;
            item_reg.desc_addr <= desc_addr;
            item_reg.desc_len <= desc_len;
            item_reg.desc_write <= desc_write;
            item_reg.desc_has_next <= desc_has_next;
            item_reg.desc_next_index <= desc_next_index;
            item_reg.access_error <= access_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg <= '0;
            entry_count_reg <= '0;
            reply_first_reg <= '0;
        end
        else if (step_go)
        begin
            walk_reg <= walk_next;
            entry_count_reg <= entry_count_next;
            reply_first_reg <= reply_first_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
            out_count_reg <= res_count;
            out_reply_start_reg <= res_reply_start;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind = out_reg.kind;
    assign fetch_addr = out_reg.fetch_addr;
    assign copy_addr = out_reg.copy_addr;
    assign copy_len = out_reg.copy_len;
    assign buf_offset = out_reg.buf_offset;
    assign desc_count = out_count_reg;
    assign req_len = out_reg.req_len;
    assign reply_idx = out_reply_start_reg;
    assign reply_len = out_reg.reply_len;
    assign end_reason = out_reg.end_reason;

    `VDCW_ASSERT_ALWAYS(a_count_cap, entry_count_reg <= CNT_W'(MAX_ENTRIES),
        "entry count above cap")
    `VDCW_ASSERT_NEXT(a_fetch_phase, res_load && res.kind == KIND_FETCH,
        walk_reg.phase == PH_DESC, "fetch issued without descriptor wait")
    `VDCW_ASSERT_NEXT(a_copy_phase, res_load && res.kind == KIND_COPY,
        walk_reg.phase == PH_COPY, "copy issued without copy wait")
    `VDCW_ASSERT_NEXT(a_summary_idle, res_load && res.kind == KIND_SUMMARY,
        walk_reg.phase == PH_IDLE, "walk not idle after summary")

endmodule
